FILE: rtl/csmab_pkg.sv
// ---------------------------------------------------------------------------
// csmab_pkg: shared types and constants for the CSMA backoff controller
// Event codes, transmit phases, result record and backoff mask helper.
// ---------------------------------------------------------------------------
package csmab_pkg;

  // Largest frame the transmit cache takes
  localparam logic [15:0] TX_CAPACITY        = 16'd256;
  localparam logic [7:0]  SILENCE_RESET      = 8'd200;
  localparam logic [15:0] BUSY_TIMEOUT_RESET = 16'd50;
  localparam int unsigned BACKOFF_BASE_BITS  = 5;
  localparam logic [15:0] BACKOFF_MAX_EXTRA  = 16'd5;

  // Configuration register indexes
  localparam logic REG_SILENCE      = 1'b0;
  localparam logic REG_BUSY_TIMEOUT = 1'b1;

  typedef enum logic [3:0] {
    ACT_TICK      = 4'd0,
    ACT_RECEIVED  = 4'd1,
    ACT_RECEIVING = 4'd2,
    ACT_TX_READY  = 4'd3,
    ACT_LOCK      = 4'd4,
    ACT_UNLOCK    = 4'd5,
    ACT_LOAD      = 4'd6,
    ACT_CLEAR     = 4'd7,
    ACT_DIRECT    = 4'd8
  } action_e;

  typedef enum logic [1:0] {
    PH_IDLE     = 2'd0,
    PH_READY    = 2'd1,
    PH_WAIT_ACK = 2'd2
  } phase_e;

  typedef enum logic [1:0] {
    LD_OK       = 2'd0,
    LD_BUSY     = 2'd1,
    LD_TOO_LONG = 2'd2
  } load_status_e;

  // One result record
  typedef struct packed {
    logic [1:0]  load_status;
    logic        request_transmit;
    logic        send_frame;
    logic [15:0] send_length;
    logic        awaiting_ack;
    logic        bus_is_busy;
    logic [1:0]  tx_status;
  } result_t;

  // Random value masked to min(retries,5)+5 bits, zero mapped to one
  function automatic logic [9:0] draw_backoff(input logic [15:0] retries,
                                              input logic [9:0]  rnd);
    logic [3:0]  extra;
    logic [10:0] mask;
    logic [9:0]  v;
    extra = (retries > BACKOFF_MAX_EXTRA) ? BACKOFF_MAX_EXTRA[3:0] : retries[3:0];
    mask  = (11'd1 << (extra + 4'(BACKOFF_BASE_BITS))) - 11'd1;
    v     = rnd & mask[9:0];
    return (v == 10'd0) ? 10'd1 : v;
  endfunction

endpackage

FILE: rtl/csma_backoff_retry_controller_unit.sv
// ---------------------------------------------------------------------------
// csma_backoff_retry_controller_unit: CSMA/CA backoff and retry controller
// Takes one medium-access event per request and returns one result each.
//
// Usage:
//   Input channel (in_valid_i / in_stall_o) carries an event code with the
//   random value, frame length and retry limit. Output channel
//   (out_valid_o / out_stall_i) returns load status, transmit request,
//   send flag and length, ack hint, bus-busy flag and transmit phase.
//   Output: an accepted request's result goes to the result register, or
//   to the skid entry while a result waits. Throughput: one request per
//   cycle while in_stall_o is low; the state update is a single pass of
//   counter logic between the state registers and the result register.
//   Stall: a two-entry output stage (result register plus skid entry) lets
//   one more request in while a result waits; in_stall_o rises only when
//   both entries hold results.
//   APB port: register 0 (addr 0) silence ticks, register 1 (addr 4) busy
//   timeout ticks; write only while the block is idle.
//   Reset: all counters clear, silence countdown and silence register load
//   200, busy timeout loads 50, transmit phase is idle, no result pending.
// ---------------------------------------------------------------------------
module csma_backoff_retry_controller_unit import csmab_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input channel
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [3:0]  action_i,
  input  logic [9:0]  random_value_i,
  input  logic [15:0] frame_length_i,
  input  logic [15:0] retry_limit_in_i,
  // output channel
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  load_status_o,
  output logic        request_transmit_o,
  output logic        send_frame_o,
  output logic [15:0] send_length_o,
  output logic        awaiting_ack_o,
  output logic        bus_is_busy_o,
  output logic [1:0]  tx_status_o,
  // configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [7:0]  silence_ticks_q;
  logic [15:0] busy_timeout_q;
  logic        cfg_wr;
  logic        accept;
  logic        take;
  result_t     res;
  result_t     out_q, skid_q;
  logic        out_valid_q, skid_valid_q;

  // Configuration registers
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      silence_ticks_q <= SILENCE_RESET;
      busy_timeout_q  <= BUSY_TIMEOUT_RESET;
    end else if (cfg_wr) begin
      if (paddr[2] == REG_SILENCE) silence_ticks_q <= pwdata[7:0];
      else                         busy_timeout_q  <= pwdata[15:0];
    end
  end

  assign prdata = (paddr[2] == REG_BUSY_TIMEOUT) ? {16'd0, busy_timeout_q}
                                                 : {24'd0, silence_ticks_q};

  // Handshake
  assign in_stall_o = skid_valid_q;
  assign accept     = in_valid_i & ~skid_valid_q;
  assign take       = out_valid_q & ~out_stall_i;

  csmab_core u_core (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .step_i           (accept),
    .action_i         (action_i),
    .random_value_i   (random_value_i),
    .frame_length_i   (frame_length_i),
    .retry_limit_in_i (retry_limit_in_i),
    .silence_ticks_i  (silence_ticks_q),
    .busy_timeout_i   (busy_timeout_q),
    .result_o         (res)
  );

  // Result register with skid entry
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (!out_valid_q || take) begin
      out_valid_q  <= skid_valid_q | accept;
      skid_valid_q <= skid_valid_q & accept;
    end else if (accept) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!out_valid_q || take) begin
      if (skid_valid_q) begin
        out_q  <= skid_q;
        skid_q <= res;
      end else begin
        out_q <= res;
      end
    end else if (accept) begin
      skid_q <= res;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign load_status_o      = out_q.load_status;
  assign request_transmit_o = out_q.request_transmit;
  assign send_frame_o       = out_q.send_frame;
  assign send_length_o      = out_q.send_length;
  assign awaiting_ack_o     = out_q.awaiting_ack;
  assign bus_is_busy_o      = out_q.bus_is_busy;
  assign tx_status_o        = out_q.tx_status;

endmodule

FILE: rtl/csmab_core.sv
// ---------------------------------------------------------------------------
// csmab_core: controller state and per-event update
// Holds bus, silence, backoff and retry state; updates it on each accepted
// request and presents that request's result combinationally.
// ---------------------------------------------------------------------------
module csmab_core import csmab_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        step_i,
  input  logic [3:0]  action_i,
  input  logic [9:0]  random_value_i,
  input  logic [15:0] frame_length_i,
  input  logic [15:0] retry_limit_in_i,
  input  logic [7:0]  silence_ticks_i,
  input  logic [15:0] busy_timeout_i,
  output result_t     result_o
);

  logic        bus_busy_q,  bus_busy_d;
  logic [15:0] busy_cnt_q,  busy_cnt_d;
  logic [7:0]  silence_q,   silence_d;
  logic [9:0]  backoff_q,   backoff_d;
  phase_e      phase_q,     phase_d;
  logic [15:0] retry_q,     retry_d;
  logic [15:0] limit_q,     limit_d;
  logic [15:0] length_q,    length_d;

  // Next state and result for the current request
  always_comb begin
    logic [15:0] busy_dec;
    logic [7:0]  sil_dec;
    logic [9:0]  bo_dec;
    logic        go;
    busy_dec   = busy_cnt_q - 16'd1;
    sil_dec    = silence_q - 8'd1;
    bo_dec     = backoff_q - 10'd1;
    go         = 1'b0;
    bus_busy_d = bus_busy_q;
    busy_cnt_d = busy_cnt_q;
    silence_d  = silence_q;
    backoff_d  = backoff_q;
    phase_d    = phase_q;
    retry_d    = retry_q;
    limit_d    = limit_q;
    length_d   = length_q;
    result_o   = '0;

    case (action_e'(action_i))
      ACT_TICK: begin
        if (bus_busy_q) begin
          busy_cnt_d = busy_dec;
          if (busy_dec == 16'd0) bus_busy_d = 1'b0;
        end else if (phase_q != PH_IDLE) begin
          // silence wait gates the retry/backoff path
          if (silence_q != 8'd0) begin
            silence_d = sil_dec;
            go        = (sil_dec == 8'd0);
          end else begin
            go = 1'b1;
          end
          if (go && phase_q == PH_WAIT_ACK) begin
            if (limit_q == 16'd0 || retry_q >= limit_q) begin
              length_d = '0;
              retry_d  = '0;
              limit_d  = '0;
              phase_d  = PH_IDLE;
              go       = 1'b0;
            end else begin
              retry_d = retry_q + 16'd1;
              phase_d = PH_READY;
            end
          end
          if (go) begin
            if (backoff_q == 10'd0) begin
              backoff_d = draw_backoff(retry_d, random_value_i);
            end else begin
              backoff_d = bo_dec;
              if (bo_dec == 10'd0) begin
                bus_busy_d                = 1'b1;
                busy_cnt_d                = busy_timeout_i;
                result_o.request_transmit = 1'b1;
              end
            end
          end
        end
      end
      ACT_RECEIVED: begin
        bus_busy_d            = 1'b0;
        busy_cnt_d            = '0;
        result_o.awaiting_ack = (phase_q == PH_WAIT_ACK);
      end
      ACT_RECEIVING, ACT_LOCK: begin
        bus_busy_d = 1'b1;
        busy_cnt_d = busy_timeout_i;
      end
      ACT_TX_READY: begin
        silence_d            = silence_ticks_i;
        result_o.send_frame  = 1'b1;
        result_o.send_length = length_q;
        phase_d              = PH_WAIT_ACK;
      end
      ACT_UNLOCK: begin
        bus_busy_d = 1'b0;
        busy_cnt_d = '0;
      end
      ACT_LOAD: begin
        if (phase_q != PH_IDLE) begin
          result_o.load_status = LD_BUSY;
        end else if (frame_length_i > TX_CAPACITY) begin
          result_o.load_status = LD_TOO_LONG;
        end else begin
          length_d = frame_length_i;
          retry_d  = '0;
          limit_d  = retry_limit_in_i;
          phase_d  = PH_READY;
        end
      end
      ACT_CLEAR: begin
        // backoff counter is kept
        length_d = '0;
        retry_d  = '0;
        limit_d  = '0;
        phase_d  = PH_IDLE;
      end
      ACT_DIRECT: begin
        result_o.send_frame  = 1'b1;
        result_o.send_length = frame_length_i;
        silence_d            = silence_ticks_i;
        bus_busy_d           = 1'b0;
        busy_cnt_d           = '0;
      end
      default: begin
      end
    endcase

    result_o.bus_is_busy = bus_busy_d;
    result_o.tx_status   = phase_d;
  end

  // State registers, updated only on an accepted request
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bus_busy_q <= 1'b0;
      busy_cnt_q <= '0;
      silence_q  <= SILENCE_RESET;
      backoff_q  <= '0;
      phase_q    <= PH_IDLE;
      retry_q    <= '0;
      limit_q    <= '0;
      length_q   <= '0;
    end else if (step_i) begin
      bus_busy_q <= bus_busy_d;
      busy_cnt_q <= busy_cnt_d;
      silence_q  <= silence_d;
      backoff_q  <= backoff_d;
      phase_q    <= phase_d;
      retry_q    <= retry_d;
      limit_q    <= limit_d;
      length_q   <= length_d;
    end
  end

endmodule

FILE: tb/sv/csma_backoff_retry_controller_unit_tb.sv
// ---------------------------------------------------------------------------
// csma_backoff_retry_controller_unit_tb: self-checking bench for the CSMA
// backoff and retry controller.
// Drives medium-access events through the valid/stall request channel,
// predicts every result with a cycle-free model of the controller state,
// and checks each returned result field by field. Stall and gap bursts on
// both channels; configuration changes over APB between traffic phases.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module csma_backoff_retry_controller_unit_tb;
  import csmab_pkg::*;

  localparam int unsigned WATCHDOG_LIMIT = 2000;

  // Clock and reset
  logic        clk_i  = 1'b0;
  logic        rst_ni = 1'b0;

  // Request channel
  logic        in_valid_i       = 1'b0;
  logic        in_stall_o;
  logic [3:0]  action_i         = '0;
  logic [9:0]  random_value_i   = '0;
  logic [15:0] frame_length_i   = '0;
  logic [15:0] retry_limit_in_i = '0;

  // Result channel
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [1:0]  load_status_o;
  logic        request_transmit_o;
  logic        send_frame_o;
  logic [15:0] send_length_o;
  logic        awaiting_ack_o;
  logic        bus_is_busy_o;
  logic [1:0]  tx_status_o;

  // APB
  logic        psel    = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite  = 1'b0;
  logic [2:0]  paddr   = '0;
  logic [31:0] pwdata  = '0;
  logic [31:0] prdata;
  logic        pready;

  csma_backoff_retry_controller_unit DUT (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid_i),
    .in_stall_o         (in_stall_o),
    .action_i           (action_i),
    .random_value_i     (random_value_i),
    .frame_length_i     (frame_length_i),
    .retry_limit_in_i   (retry_limit_in_i),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .load_status_o      (load_status_o),
    .request_transmit_o (request_transmit_o),
    .send_frame_o       (send_frame_o),
    .send_length_o      (send_length_o),
    .awaiting_ack_o     (awaiting_ack_o),
    .bus_is_busy_o      (bus_is_busy_o),
    .tx_status_o        (tx_status_o),
    .psel               (psel),
    .penable            (penable),
    .pwrite             (pwrite),
    .paddr              (paddr),
    .pwdata             (pwdata),
    .prdata             (prdata),
    .pready             (pready)
  );

  // MAC model state and its copy of the registers
  logic [7:0]  cfg_silence      = SILENCE_RESET;
  logic [15:0] cfg_busy_timeout = BUSY_TIMEOUT_RESET;
  logic        mac_bus_busy     = 1'b0;
  logic [15:0] mac_busy_cnt     = '0;
  logic [7:0]  mac_silence_cnt  = SILENCE_RESET;
  logic [9:0]  mac_backoff      = '0;
  phase_e      mac_phase        = PH_IDLE;
  logic [15:0] mac_retries      = '0;
  logic [15:0] mac_retry_limit  = '0;
  logic [15:0] mac_cached_len   = '0;

  result_t     pending_results[$];
  int unsigned mismatch_count = 0;
  int unsigned quiet_cycles   = 0;

  // Traffic shaping
  bit          idling_on    = 1'b1;
  int          stall_left   = 0;
  int          stall_calm   = 0;
  int          gap_calm     = 0;
  logic        last_request = 1'b0;
  logic        last_ack     = 1'b0;

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  // --- MAC model -----------------------------------------------------------
  task automatic mac_lock_bus();
    mac_bus_busy = 1'b1;
    mac_busy_cnt = cfg_busy_timeout;
  endtask

  task automatic mac_unlock_bus();
    mac_bus_busy = 1'b0;
    mac_busy_cnt = '0;
  endtask

  task automatic mac_clear_frame();
    mac_cached_len  = '0;
    mac_retries     = '0;
    mac_retry_limit = '0;
    mac_phase       = PH_IDLE;
  endtask

  // Advance the model by one request and return the result it produces
  task automatic mac_step(input logic [3:0] act, input logic [9:0] rnd,
                          input logic [15:0] flen, input logic [15:0] rlim,
                          output result_t r);
    logic        go;
    int unsigned extra;
    logic [9:0]  drawn;
    r = '0;
    case (act)
      ACT_TICK: begin
        if (mac_bus_busy) begin
          // busy countdown wraps, so a zero timeout holds for 65536 ticks
          mac_busy_cnt = mac_busy_cnt - 16'd1;
          if (mac_busy_cnt == 16'd0) mac_unlock_bus();
        end else if (mac_phase != PH_IDLE) begin
          go = 1'b1;
          if (mac_silence_cnt != 8'd0) begin
            mac_silence_cnt = mac_silence_cnt - 8'd1;
            go = (mac_silence_cnt == 8'd0);
          end
          // no ack arrived: retry or give up
          if (go && mac_phase == PH_WAIT_ACK) begin
            if (mac_retry_limit == 16'd0 || mac_retries >= mac_retry_limit) begin
              mac_clear_frame();
              go = 1'b0;
            end else begin
              mac_retries = mac_retries + 16'd1;
              mac_phase   = PH_READY;
            end
          end
          if (go) begin
            if (mac_backoff == 10'd0) begin
              extra = (mac_retries > BACKOFF_MAX_EXTRA) ? BACKOFF_MAX_EXTRA : mac_retries;
              drawn = rnd & 10'((1 << (extra + BACKOFF_BASE_BITS)) - 1);
              mac_backoff = (drawn == 10'd0) ? 10'd1 : drawn;
            end else begin
              mac_backoff = mac_backoff - 10'd1;
              if (mac_backoff == 10'd0) begin
                mac_lock_bus();
                r.request_transmit = 1'b1;
              end
            end
          end
        end
      end
      ACT_RECEIVED: begin
        mac_unlock_bus();
        r.awaiting_ack = (mac_phase == PH_WAIT_ACK);
      end
      ACT_RECEIVING, ACT_LOCK: mac_lock_bus();
      ACT_TX_READY: begin
        mac_silence_cnt = cfg_silence;
        r.send_frame    = 1'b1;
        r.send_length   = mac_cached_len;
        mac_phase       = PH_WAIT_ACK;
      end
      ACT_UNLOCK: mac_unlock_bus();
      ACT_LOAD: begin
        if (mac_phase != PH_IDLE) begin
          r.load_status = LD_BUSY;
        end else if (flen > TX_CAPACITY) begin
          r.load_status = LD_TOO_LONG;
        end else begin
          mac_cached_len  = flen;
          mac_retries     = '0;
          mac_retry_limit = rlim;
          mac_phase       = PH_READY;
        end
      end
      ACT_CLEAR: mac_clear_frame();
      ACT_DIRECT: begin
        r.send_frame    = 1'b1;
        r.send_length   = flen;
        mac_silence_cnt = cfg_silence;
        mac_unlock_bus();
      end
      default: ;
    endcase
    r.bus_is_busy = mac_bus_busy;
    r.tx_status   = mac_phase;
  endtask

  // --- Request driver ------------------------------------------------------
  task automatic send_request(input logic [3:0] act, input logic [9:0] rnd,
                              input logic [15:0] flen, input logic [15:0] rlim);
    result_t r;
    if (idling_on && gap_calm == 0 && $urandom_range(0, 4) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    if (gap_calm > 0) gap_calm--;
    else if ($urandom_range(0, 29) == 0) gap_calm = $urandom_range(10, 30);
    in_valid_i       <= 1'b1;
    action_i         <= act;
    random_value_i   <= rnd;
    frame_length_i   <= flen;
    retry_limit_in_i <= rlim;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    mac_step(act, rnd, flen, rlim, r);
    pending_results.push_back(r);
    last_request = r.request_transmit;
    last_ack     = r.awaiting_ack;
  endtask

  // Hold the sender until every outstanding result is back
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic idx, input logic [31:0] val);
    wait_drained();
    repeat (2) @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (idx == REG_SILENCE) cfg_silence = val[7:0];
    else cfg_busy_timeout = val[15:0];
  endtask

  // --- Result checker ------------------------------------------------------
  task automatic check_field(input string name, input logic [15:0] want,
                             input logic [15:0] got);
    if (want !== got) begin
      mismatch_count++;
      $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
    end
  endtask

  always @(posedge clk_i) begin
    result_t want;
    result_t got;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got = {load_status_o, request_transmit_o, send_frame_o, send_length_o,
             awaiting_ack_o, bus_is_busy_o, tx_status_o};
      if (pending_results.size() == 0) begin
        mismatch_count++;
        $display("%0t: result with none expected, expected none actual %h", $time, got);
      end else begin
        want = pending_results.pop_front();
        check_field("load_status", 16'(want.load_status), 16'(got.load_status));
        check_field("request_transmit", 16'(want.request_transmit),
                    16'(got.request_transmit));
        check_field("send_frame", 16'(want.send_frame), 16'(got.send_frame));
        check_field("send_length", want.send_length, got.send_length);
        check_field("awaiting_ack", 16'(want.awaiting_ack), 16'(got.awaiting_ack));
        check_field("bus_is_busy", 16'(want.bus_is_busy), 16'(got.bus_is_busy));
        check_field("tx_status", 16'(want.tx_status), 16'(got.tx_status));
      end
    end
  end

  // Result-side stall bursts with calm stretches in between
  always @(posedge clk_i) begin
    if (!idling_on) begin
      out_stall_i <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_stall_i <= 1'b1;
    end else if (stall_calm > 0) begin
      stall_calm--;
      out_stall_i <= 1'b0;
    end else begin
      case ($urandom_range(0, 5))
        0, 1: begin
          stall_left = $urandom_range(0, 3);
          out_stall_i <= 1'b1;
        end
        2: begin
          stall_calm = $urandom_range(8, 40);
          out_stall_i <= 1'b0;
        end
        default: out_stall_i <= 1'b0;
      endcase
    end
  end

  // Watchdog on handshake progress
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
        quiet_cycles <= 0;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
          $display("csma_backoff_retry_controller_unit_tb: done, errors");
          $finish;
        end
      end
    end
  end

  // --- Directed tests ------------------------------------------------------
  // Ticks while idle do nothing; unknown codes leave all state alone
  task automatic test_idle_and_unknown_codes();
    send_request(ACT_TICK, 10'h3FF, 16'hFFFF, 16'hFFFF);
    send_request(4'd9, 10'h3FF, 16'hFFFF, 16'hFFFF);
    send_request(4'd15, 10'h3FF, 16'hFFFF, 16'hFFFF);
  endtask

  // Load accepted, busy, too long; zero length and capacity edge
  task automatic test_load_outcomes();
    send_request(ACT_LOAD, 10'h000, 16'd0, 16'd0);
    send_request(ACT_LOAD, 10'h000, 16'd1, 16'd1);
    send_request(ACT_CLEAR, 10'h000, 16'd0, 16'd0);
    send_request(ACT_LOAD, 10'h000, 16'd257, 16'd2);
    send_request(ACT_LOAD, 10'h000, 16'hFFFF, 16'hFFFF);
    send_request(ACT_LOAD, 10'h000, TX_CAPACITY, 16'hFFFF);
    send_request(ACT_CLEAR, 10'h000, 16'd0, 16'd0);
  endtask

  // Direct send unlocks the bus; tx ready while idle sends the empty cache
  task automatic test_send_paths();
    send_request(ACT_LOCK, 10'h000, 16'd0, 16'd0);
    send_request(ACT_DIRECT, 10'h000, 16'hFFFF, 16'd0);
    send_request(ACT_TX_READY, 10'h000, 16'd0, 16'd0);
    send_request(ACT_RECEIVED, 10'h000, 16'd0, 16'd0);
    send_request(ACT_RECEIVING, 10'h000, 16'd0, 16'd0);
    send_request(ACT_UNLOCK, 10'h000, 16'd0, 16'd0);
    send_request(ACT_CLEAR, 10'h000, 16'd0, 16'd0);
  endtask

  // No silence wait, zero busy timeout wraps the countdown, zero draw maps to one
  task automatic test_zero_silence_and_timeout();
    write_reg(REG_SILENCE, 32'd0);
    write_reg(REG_BUSY_TIMEOUT, 32'd0);
    send_request(ACT_LOAD, 10'h000, 16'd4, 16'd1);
    send_request(ACT_LOCK, 10'h000, 16'd0, 16'd0);
    send_request(ACT_TICK, 10'h000, 16'd0, 16'd0);
    send_request(ACT_RECEIVED, 10'h000, 16'd0, 16'd0);
    send_request(ACT_TX_READY, 10'h000, 16'd0, 16'd0);
    send_request(ACT_TICK, 10'h000, 16'd0, 16'd0);
    send_request(ACT_TICK, 10'h3FF, 16'd0, 16'd0);
    send_request(ACT_TICK, 10'h000, 16'd0, 16'd0);
    send_request(ACT_UNLOCK, 10'h000, 16'd0, 16'd0);
    send_request(ACT_CLEAR, 10'h000, 16'd0, 16'd0);
  endtask

  // --- Random traffic ------------------------------------------------------
  // Mostly well-formed frame exchanges steered by the model state, some noise
  task automatic pick_request(output logic [3:0] act, output logic [9:0] rnd,
                              output logic [15:0] flen, output logic [15:0] rlim);
    int unsigned roll;
    rnd  = ($urandom_range(0, 7) == 0) ? 10'($urandom) : 10'($urandom_range(0, 7));
    flen = ($urandom_range(0, 7) == 0) ? 16'($urandom) : 16'($urandom_range(0, 300));
    rlim = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 3));
    roll = $urandom_range(0, 99);
    if (roll < 8) act = 4'($urandom_range(0, 15));
    else if (last_request && roll < 90) act = ACT_TX_READY;
    else if (last_ack && roll < 60) act = ACT_CLEAR;
    else if (mac_bus_busy)
      act = (roll < 20) ? ACT_RECEIVED : ((roll < 24) ? ACT_UNLOCK : ACT_TICK);
    else if (mac_phase == PH_IDLE)
      act = (roll < 50) ? ACT_LOAD : ((roll < 55) ? ACT_DIRECT :
            ((roll < 60) ? ACT_RECEIVING : ACT_TICK));
    else if (mac_phase == PH_WAIT_ACK)
      act = (roll < 30) ? ACT_RECEIVED : ((roll < 34) ? ACT_CLEAR : ACT_TICK);
    else
      act = (roll < 11) ? ACT_CLEAR : ((roll < 13) ? ACT_LOAD : ACT_TICK);
  endtask

  task automatic test_random_traffic(input int count, input logic [7:0] silence,
                                     input logic [15:0] timeout, input bit with_idling);
    logic [3:0]  act;
    logic [9:0]  rnd;
    logic [15:0] flen;
    logic [15:0] rlim;
    write_reg(REG_SILENCE, 32'(silence));
    write_reg(REG_BUSY_TIMEOUT, 32'(timeout));
    idling_on = with_idling;
    for (int n = 0; n < count; n++) begin
      pick_request(act, rnd, flen, rlim);
      send_request(act, rnd, flen, rlim);
      if ($urandom_range(0, 99) == 0) wait_drained();
    end
  endtask

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_idle_and_unknown_codes();
    test_load_outcomes();
    test_send_paths();
    test_zero_silence_and_timeout();

    test_random_traffic(375, 8'd3, 16'd4, 1'b1);
    test_random_traffic(375, 8'd1, 16'd1, 1'b1);
    test_random_traffic(375, 8'd255, 16'hFFFF, 1'b1);
    test_random_traffic(375, 8'($urandom_range(1, 20)), 16'($urandom_range(1, 10)), 1'b0);

    wait_drained();
    repeat (8) @(posedge clk_i);
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("csma_backoff_retry_controller_unit_tb: done, clean");
    end else begin
      $display("csma_backoff_retry_controller_unit_tb: done, errors");
    end
    $finish;
  end

endmodule

FILE: csma_backoff_retry_controller_unit.f
rtl/csmab_pkg.sv
rtl/csmab_core.sv
rtl/csma_backoff_retry_controller_unit.sv
tb/sv/csma_backoff_retry_controller_unit_tb.sv
